@@ rtl/core/chs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_pkg
// Shared types and constants of the convex hull scan unit.
// ----------------------------------------------------------------------------
package chs_pkg;

    localparam int MAX_POINTS_DEF = 32;
    localparam int COORD_BITS_DEF = 16;
    localparam int FIELD_W        = 16;

    localparam logic KIND_HULL    = 1'b0;
    localparam logic KIND_REMOVED = 1'b1;

    typedef struct packed {
        logic signed [FIELD_W-1:0] x_coord;
        logic signed [FIELD_W-1:0] y_coord;
        logic                      last_point;
    } pt_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] x_out;
        logic signed [FIELD_W-1:0] y_out;
        logic                      kind;
        logic                      last_out;
    } hull_t;

    typedef struct packed {
        logic done;
        logic left;
        logic right;
    } orient_res_t;

endpackage

@@ rtl/core/chs_orient.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_orient
// Shared orientation unit: sign of the turn o -> a -> b, one multiplier
// used twice; the sign is registered in the compare state U_CMP.
// ----------------------------------------------------------------------------
module chs_orient #(
    parameter int COORD_BITS = chs_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [COORD_BITS-1:0]  ox,
    input  logic signed [COORD_BITS-1:0]  oy,
    input  logic signed [COORD_BITS-1:0]  ax,
    input  logic signed [COORD_BITS-1:0]  ay,
    input  logic signed [COORD_BITS-1:0]  bx,
    input  logic signed [COORD_BITS-1:0]  by,
    output chs_pkg::orient_res_t          res
);
    import chs_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    typedef enum logic [1:0] {U_IDLE, U_MUL1, U_MUL2, U_CMP} ustate_t;

    ustate_t              state_reg;
    logic signed [DW-1:0] d1_reg, d2_reg, d3_reg, d4_reg;
    logic signed [PW-1:0] p1_reg, p2_reg;
    orient_res_t          res_reg;

    logic signed [DW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod;
    logic signed [PW:0]   diff;

    always_comb
    begin
        if (state_reg == U_MUL1)
        begin
            mul_a = d1_reg;
            mul_b = d2_reg;
        end
        else
        begin
            mul_a = d3_reg;
            mul_b = d4_reg;
        end
    end

    assign prod = mul_a * mul_b;
    assign diff = {p1_reg[PW-1], p1_reg} - {p2_reg[PW-1], p2_reg};
    assign res  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            d1_reg    <= '0;
            d2_reg    <= '0;
            d3_reg    <= '0;
            d4_reg    <= '0;
            p1_reg    <= '0;
            p2_reg    <= '0;
            res_reg   <= '0;
        end
        else
        begin
            res_reg.done <= 1'b0;
            case (state_reg)
                U_IDLE:
                begin
                    if (start)
                    begin
                        d1_reg    <= {ax[COORD_BITS-1], ax} - {ox[COORD_BITS-1], ox};
                        d2_reg    <= {by[COORD_BITS-1], by} - {oy[COORD_BITS-1], oy};
                        d3_reg    <= {ay[COORD_BITS-1], ay} - {oy[COORD_BITS-1], oy};
                        d4_reg    <= {bx[COORD_BITS-1], bx} - {ox[COORD_BITS-1], ox};
                        state_reg <= U_MUL1;
                    end
                end
                U_MUL1:
                begin
                    p1_reg    <= prod;
                    state_reg <= U_MUL2;
                end
                U_MUL2:
                begin
                    p2_reg    <= prod;
                    state_reg <= U_CMP;
                end
                U_CMP:
                begin
                    res_reg.done  <= 1'b1;
                    res_reg.right <= diff[PW];
                    res_reg.left  <= !diff[PW] && (diff != '0);
                    state_reg     <= U_IDLE;
                end
                default:
                begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/chs_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_seq
// Sequencer with point, order, stack and removed memories: load, start
// search, insertion sort, scan and result fetch.
// ----------------------------------------------------------------------------
module chs_seq #(
    parameter int MAX_POINTS = chs_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = chs_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          acc,
    input  chs_pkg::pt_t                  item,
    output logic                          ready,
    output logic                          emit,
    output chs_pkg::hull_t                result,
    output logic                          orient_start,
    output logic signed [COORD_BITS-1:0]  op_ox,
    output logic signed [COORD_BITS-1:0]  op_oy,
    output logic signed [COORD_BITS-1:0]  op_ax,
    output logic signed [COORD_BITS-1:0]  op_ay,
    output logic signed [COORD_BITS-1:0]  op_bx,
    output logic signed [COORD_BITS-1:0]  op_by,
    input  chs_pkg::orient_res_t          ores
);
    import chs_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int PW = $clog2(MAX_POINTS + 2);

    typedef enum logic [4:0] {
        S_LOAD, S_MIN_RD, S_MIN_CMP,
        S_SORT_RD, S_SORT_A, S_SORT_J, S_SORT_B1, S_SORT_B2, S_SORT_GO, S_SORT_OR,
        S_SORT_INS, S_SORT_NEXT,
        S_SCAN_INIT, S_SCAN_RD, S_SCAN_K1, S_SCAN_K2, S_SCAN_CHK, S_SCAN_O1,
        S_SCAN_O2, S_SCAN_GO, S_SCAN_OR, S_SCAN_PUSH, S_SCAN_NEXT,
        S_EMIT_IDX, S_EMIT_PT, S_EMIT_OUT, S_EMIT_WAIT
    } state_t;

    function automatic logic [C-1:0] coord_in(input logic [FIELD_W-1:0] v);
        logic [C-1:0] r;
        r = '0;
        for (int k = 0; k < C; k++)
        begin
            if (k < FIELD_W)
                r[k] = v[k];
        end
        return r;
    endfunction

    function automatic logic [FIELD_W-1:0] coord_out(input logic [C-1:0] v);
        logic [FIELD_W-1:0] r;
        for (int k = 0; k < FIELD_W; k++)
        begin
            r[k] = (k < C) ? v[k] : v[C-1];
        end
        return r;
    endfunction

    // memories
    logic [2*C-1:0] pmem [MAX_POINTS];
    logic [IW-1:0]  smem [MAX_POINTS];
    logic [IW-1:0]  kmem [MAX_POINTS];
    logic [IW-1:0]  rmem [MAX_POINTS];

    logic [2*C-1:0] p_rd;
    logic [IW-1:0]  s_rd, k_rd, r_rd;
    logic [IW-1:0]  pa, sa, ka, ra;
    logic           pwe, swe, kwe, rwe;
    logic [IW-1:0]  swa, kwa;
    logic [IW-1:0]  swd, kwd;

    state_t               state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        i_reg, i_next;
    logic [CW-1:0]        j_reg, j_next;
    logic [CW-1:0]        n_reg, n_next;
    logic [CW-1:0]        depth_reg, depth_next;
    logic [CW-1:0]        rc_reg, rc_next;
    logic [PW-1:0]        pos_reg, pos_next;
    logic [IW-1:0]        sidx_reg, sidx_next;
    logic signed [C-1:0]  sx_reg, sx_next, sy_reg, sy_next;
    logic [IW-1:0]        aidx_reg, aidx_next;
    logic signed [C-1:0]  ax_reg, ax_next, ay_reg, ay_next;
    logic [IW-1:0]        bidx_reg, bidx_next;
    logic signed [C-1:0]  bx_reg, bx_next, by_reg, by_next;
    logic [IW-1:0]        oidx_reg, oidx_next;
    logic signed [C-1:0]  ox_reg, ox_next, oy_reg, oy_next;
    logic [IW-1:0]        tidx_reg, tidx_next;
    logic signed [C-1:0]  tx_reg, tx_next, ty_reg, ty_next;

    logic signed [C-1:0]  px, py;
    logic [PW-1:0]        depth_p, total_p, rpos;
    logic [IW-1:0]        emit_idx;
    logic                 tie_first;

    assign px = $signed(p_rd[2*C-1:C]);
    assign py = $signed(p_rd[C-1:0]);

    assign depth_p = PW'(depth_reg);
    assign total_p = depth_p + PW'(rc_reg) + PW'(1);
    assign rpos    = pos_reg - depth_p - PW'(1);

    always_comb
    begin
        if (pos_reg < depth_p)
            emit_idx = k_rd;
        else if (pos_reg == depth_p)
            emit_idx = sidx_reg;
        else
            emit_idx = r_rd;
    end

    // collinear with the start: nearer first by x then y
    assign tie_first = (ax_reg < bx_reg) || ((ax_reg == bx_reg) && (ay_reg < by_reg));

    assign ready        = (state_reg == S_LOAD) || (state_reg == S_EMIT_WAIT);
    assign emit         = (state_reg == S_EMIT_OUT);
    assign orient_start = (state_reg == S_SORT_GO) || (state_reg == S_SCAN_GO);

    always_comb
    begin
        result.x_out    = $signed(coord_out(p_rd[2*C-1:C]));
        result.y_out    = $signed(coord_out(p_rd[C-1:0]));
        result.kind     = (pos_reg > depth_p) ? KIND_REMOVED : KIND_HULL;
        result.last_out = (pos_reg + PW'(1) == total_p);
    end

    always_comb
    begin
        if (state_reg == S_SCAN_GO)
        begin
            op_ox = ox_reg;
            op_oy = oy_reg;
            op_ax = tx_reg;
            op_ay = ty_reg;
            op_bx = ax_reg;
            op_by = ay_reg;
        end
        else
        begin
            op_ox = sx_reg;
            op_oy = sy_reg;
            op_ax = ax_reg;
            op_ay = ay_reg;
            op_bx = bx_reg;
            op_by = by_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_rd <= pmem[pa];
        s_rd <= smem[sa];
        k_rd <= kmem[ka];
        r_rd <= rmem[ra];
        if (pwe)
            pmem[cnt_reg[IW-1:0]] <= {coord_in(item.x_coord), coord_in(item.y_coord)};
        if (swe)
            smem[swa] <= swd;
        if (kwe)
            kmem[kwa] <= kwd;
        if (rwe)
            rmem[rc_reg[IW-1:0]] <= tidx_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        n_next     = n_reg;
        depth_next = depth_reg;
        rc_next    = rc_reg;
        pos_next   = pos_reg;
        sidx_next  = sidx_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        aidx_next  = aidx_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        bidx_next  = bidx_reg;
        bx_next    = bx_reg;
        by_next    = by_reg;
        oidx_next  = oidx_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        tidx_next  = tidx_reg;
        tx_next    = tx_reg;
        ty_next    = ty_reg;

        pa  = i_reg[IW-1:0];
        sa  = i_reg[IW-1:0];
        ka  = '0;
        ra  = '0;
        pwe = 1'b0;
        swe = 1'b0;
        kwe = 1'b0;
        rwe = 1'b0;
        swa = j_reg[IW-1:0];
        swd = aidx_reg;
        kwa = depth_reg[IW-1:0];
        kwd = aidx_reg;

        case (state_reg)
            S_LOAD:
            begin
                if (acc)
                begin
                    if (cnt_reg < CW'(MAX_POINTS))
                    begin
                        pwe      = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    if (item.last_point)
                    begin
                        i_next     = '0;
                        state_next = S_MIN_RD;
                    end
                end
            end
            S_MIN_RD:
            begin
                state_next = S_MIN_CMP;
            end
            S_MIN_CMP:
            begin
                if ((i_reg == '0) || (px < sx_reg) || ((px == sx_reg) && (py < sy_reg)))
                begin
                    sidx_next = i_reg[IW-1:0];
                    sx_next   = px;
                    sy_next   = py;
                end
                i_next = i_reg + CW'(1);
                if (i_reg + CW'(1) == cnt_reg)
                begin
                    i_next     = '0;
                    n_next     = '0;
                    state_next = S_SORT_RD;
                end
                else
                begin
                    state_next = S_MIN_RD;
                end
            end
            S_SORT_RD:
            begin
                state_next = S_SORT_A;
            end
            S_SORT_A:
            begin
                aidx_next = i_reg[IW-1:0];
                ax_next   = px;
                ay_next   = py;
                if ((i_reg[IW-1:0] == sidx_reg) || ((px == sx_reg) && (py == sy_reg)))
                begin
                    state_next = S_SORT_NEXT;
                end
                else
                begin
                    j_next     = n_reg;
                    state_next = S_SORT_J;
                end
            end
            S_SORT_J:
            begin
                sa = IW'(j_reg - CW'(1));
                if (j_reg == '0)
                    state_next = S_SORT_INS;
                else
                    state_next = S_SORT_B1;
            end
            S_SORT_B1:
            begin
                pa         = s_rd;
                bidx_next  = s_rd;
                state_next = S_SORT_B2;
            end
            S_SORT_B2:
            begin
                bx_next    = px;
                by_next    = py;
                state_next = S_SORT_GO;
            end
            S_SORT_GO:
            begin
                state_next = S_SORT_OR;
            end
            S_SORT_OR:
            begin
                if (ores.done)
                begin
                    if (ores.left || (!ores.right && tie_first))
                    begin
                        swe        = 1'b1;
                        swd        = bidx_reg;
                        j_next     = j_reg - CW'(1);
                        state_next = S_SORT_J;
                    end
                    else
                    begin
                        state_next = S_SORT_INS;
                    end
                end
            end
            S_SORT_INS:
            begin
                swe        = 1'b1;
                n_next     = n_reg + CW'(1);
                state_next = S_SORT_NEXT;
            end
            S_SORT_NEXT:
            begin
                i_next = i_reg + CW'(1);
                if (i_reg + CW'(1) == cnt_reg)
                    state_next = S_SCAN_INIT;
                else
                    state_next = S_SORT_RD;
            end
            S_SCAN_INIT:
            begin
                kwe        = 1'b1;
                kwa        = '0;
                kwd        = sidx_reg;
                depth_next = CW'(1);
                rc_next    = '0;
                pos_next   = '0;
                tidx_next  = sidx_reg;
                tx_next    = sx_reg;
                ty_next    = sy_reg;
                i_next     = '0;
                if (n_reg == '0)
                    state_next = S_EMIT_IDX;
                else
                    state_next = S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_K1;
            end
            S_SCAN_K1:
            begin
                pa         = s_rd;
                aidx_next  = s_rd;
                state_next = S_SCAN_K2;
            end
            S_SCAN_K2:
            begin
                ax_next = px;
                ay_next = py;
                if ((px == tx_reg) && (py == ty_reg))
                    state_next = S_SCAN_NEXT;
                else
                    state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                ka = IW'(depth_reg - CW'(2));
                if (depth_reg >= CW'(2))
                    state_next = S_SCAN_O1;
                else
                    state_next = S_SCAN_PUSH;
            end
            S_SCAN_O1:
            begin
                pa         = k_rd;
                oidx_next  = k_rd;
                state_next = S_SCAN_O2;
            end
            S_SCAN_O2:
            begin
                ox_next    = px;
                oy_next    = py;
                state_next = S_SCAN_GO;
            end
            S_SCAN_GO:
            begin
                state_next = S_SCAN_OR;
            end
            S_SCAN_OR:
            begin
                if (ores.done)
                begin
                    if (ores.right)
                    begin
                        // pop the top, the point below becomes the top
                        rwe        = 1'b1;
                        rc_next    = rc_reg + CW'(1);
                        depth_next = depth_reg - CW'(1);
                        tidx_next  = oidx_reg;
                        tx_next    = ox_reg;
                        ty_next    = oy_reg;
                        state_next = S_SCAN_CHK;
                    end
                    else
                    begin
                        state_next = S_SCAN_PUSH;
                    end
                end
            end
            S_SCAN_PUSH:
            begin
                kwe        = 1'b1;
                depth_next = depth_reg + CW'(1);
                tidx_next  = aidx_reg;
                tx_next    = ax_reg;
                ty_next    = ay_reg;
                state_next = S_SCAN_NEXT;
            end
            S_SCAN_NEXT:
            begin
                i_next = i_reg + CW'(1);
                if (i_reg + CW'(1) == n_reg)
                    state_next = S_EMIT_IDX;
                else
                    state_next = S_SCAN_RD;
            end
            S_EMIT_IDX:
            begin
                ka         = pos_reg[IW-1:0];
                ra         = rpos[IW-1:0];
                state_next = S_EMIT_PT;
            end
            S_EMIT_PT:
            begin
                pa         = emit_idx;
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                pos_next = pos_reg + PW'(1);
                if (pos_reg + PW'(1) == total_p)
                begin
                    pos_next   = '0;
                    cnt_next   = '0;
                    depth_next = '0;
                    rc_next    = '0;
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_EMIT_WAIT;
                end
            end
            S_EMIT_WAIT:
            begin
                if (acc)
                    state_next = S_EMIT_IDX;
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            n_reg     <= '0;
            depth_reg <= '0;
            rc_reg    <= '0;
            pos_reg   <= '0;
            sidx_reg  <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            aidx_reg  <= '0;
            ax_reg    <= '0;
            ay_reg    <= '0;
            bidx_reg  <= '0;
            bx_reg    <= '0;
            by_reg    <= '0;
            oidx_reg  <= '0;
            ox_reg    <= '0;
            oy_reg    <= '0;
            tidx_reg  <= '0;
            tx_reg    <= '0;
            ty_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            n_reg     <= n_next;
            depth_reg <= depth_next;
            rc_reg    <= rc_next;
            pos_reg   <= pos_next;
            sidx_reg  <= sidx_next;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            aidx_reg  <= aidx_next;
            ax_reg    <= ax_next;
            ay_reg    <= ay_next;
            bidx_reg  <= bidx_next;
            bx_reg    <= bx_next;
            by_reg    <= by_next;
            oidx_reg  <= oidx_next;
            ox_reg    <= ox_next;
            oy_reg    <= oy_next;
            tidx_reg  <= tidx_next;
            tx_reg    <= tx_next;
            ty_reg    <= ty_next;
        end
    end

endmodule

@@ rtl/core/convex_hull_scan_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convex_hull_scan_unit
// Graham scan convex hull over up to MAX_POINTS stored points.
// ----------------------------------------------------------------------------
// Points load at one transaction per cycle while pt_stall is low and give no
// result until the one marked last_point. Then the unit finds the start point,
// insertion-sorts the rest around it (up to n*n/2 comparisons) and runs the
// scan, all through one shared orientation unit with a single multiplier;
// the orientation unit and the serial memory reads set the pace. The first
// result follows the scan through S_EMIT_IDX, S_EMIT_PT and S_EMIT_OUT into
// the output register; each later transaction in is taken in S_EMIT_WAIT and
// yields the next result through those states. Results are the hull from the
// start point back to it, then the popped points; a new point set loads
// after the result marked last_out.
module convex_hull_scan_unit #(
    parameter int MAX_POINTS = chs_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = chs_pkg::COORD_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pt_valid,
    output logic           pt_stall,
    input  chs_pkg::pt_t   pt,
    output logic           hull_valid,
    input  logic           hull_stall,
    output chs_pkg::hull_t hull
);
    import chs_pkg::*;

    logic                         ready, emit, acc, orient_start;
    hull_t                        result;
    hull_t                        hull_reg;
    logic                         hull_valid_reg;
    orient_res_t                  ores;
    logic signed [COORD_BITS-1:0] op_ox, op_oy, op_ax, op_ay, op_bx, op_by;

    assign pt_stall   = !ready || hull_valid_reg;
    assign acc        = pt_valid && !pt_stall;
    assign hull_valid = hull_valid_reg;
    assign hull       = hull_reg;

    chs_seq #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .acc          (acc),
        .item         (pt),
        .ready        (ready),
        .emit         (emit),
        .result       (result),
        .orient_start (orient_start),
        .op_ox        (op_ox),
        .op_oy        (op_oy),
        .op_ax        (op_ax),
        .op_ay        (op_ay),
        .op_bx        (op_bx),
        .op_by        (op_by),
        .ores         (ores)
    );

    chs_orient #(
        .COORD_BITS (COORD_BITS)
    ) u_orient (
        .clk   (clk),
        .rst_n (rst_n),
        .start (orient_start),
        .ox    (op_ox),
        .oy    (op_oy),
        .ax    (op_ax),
        .ay    (op_ay),
        .bx    (op_bx),
        .by    (op_by),
        .res   (ores)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hull_valid_reg <= 1'b0;
            hull_reg       <= '0;
        end
        else
        begin
            if (emit)
            begin
                hull_valid_reg <= 1'b1;
                hull_reg       <= result;
            end
            else if (hull_valid_reg && !hull_stall)
            begin
                hull_valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/core/chs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_checker
// Port-level checks of the convex hull scan unit, bound to the top level.
// ----------------------------------------------------------------------------
module chs_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           pt_valid,
    input logic           pt_stall,
    input chs_pkg::pt_t   pt,
    input logic           hull_valid,
    input logic           hull_stall,
    input chs_pkg::hull_t hull
);
    import chs_pkg::*;

    // a held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hull_valid && hull_stall |=> hull_valid && $stable(hull))
        else $error("result changed while stalled");

    // no new transaction in while a result waits
    a_block: assert property (@(posedge clk) disable iff (!rst_n)
        hull_valid |-> pt_stall)
        else $error("input taken while result pending");

    // a taken result is never followed directly by another
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        hull_valid && !hull_stall |=> !hull_valid)
        else $error("results back to back");

    // the last point needs the scan before any result
    a_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pt_valid && !pt_stall && pt.last_point |=> !hull_valid)
        else $error("result without scan");

endmodule

bind convex_hull_scan_unit chs_checker u_chs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pt_valid   (pt_valid),
    .pt_stall   (pt_stall),
    .pt         (pt),
    .hull_valid (hull_valid),
    .hull_stall (hull_stall),
    .hull       (hull)
);

@@ bench/convex_hull_scan_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convex_hull_scan_checker
// Watches the point and hull channels, computes the expected hull output of
// every point set with its own Graham scan and compares each hull transaction.
// ----------------------------------------------------------------------------
module convex_hull_scan_checker #(
    parameter int MAX_POINTS = chs_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = chs_pkg::COORD_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pt_valid,
    input  logic           pt_stall,
    input  chs_pkg::pt_t   pt,
    input  logic           hull_valid,
    input  logic           hull_stall,
    input  chs_pkg::hull_t hull,
    output int             fail_count,
    output int             pending
);
    import chs_pkg::*;

    longint pts_x [MAX_POINTS];
    longint pts_y [MAX_POINTS];
    int     num_pts;
    bit     emitting;
    int     start_pt;
    hull_t  hull_queue [$];

    assign pending = hull_queue.size();

    function automatic longint sext_coord(logic [FIELD_W-1:0] raw);
        logic [63:0] v;
        v = 64'(raw) & ((64'd1 << COORD_BITS) - 64'd1);
        v = v ^ (64'd1 << (COORD_BITS - 1));
        return longint'(v) - (longint'(1) << (COORD_BITS - 1));
    endfunction

    // sign of turn o -> a -> b, products kept exact in 128 bits
    function automatic int turn_sign(int o, int a, int b);
        logic signed [127:0] da;
        logic signed [127:0] db;
        logic signed [127:0] dc;
        logic signed [127:0] dd;
        logic signed [127:0] lhs;
        logic signed [127:0] rhs;
        da  = pts_x[a] - pts_x[o];
        db  = pts_y[b] - pts_y[o];
        dc  = pts_y[a] - pts_y[o];
        dd  = pts_x[b] - pts_x[o];
        lhs = da * db;
        rhs = dc * dd;
        return (lhs > rhs) ? 1 : ((lhs < rhs) ? -1 : 0);
    endfunction

    function automatic bit same_pt(int a, int b);
        return pts_x[a] == pts_x[b] && pts_y[a] == pts_y[b];
    endfunction

    function automatic bit goes_first(int a, int b);
        int c;
        c = turn_sign(start_pt, a, b);
        if (c != 0)
            return c > 0;
        if (pts_x[a] != pts_x[b])
            return pts_x[a] < pts_x[b];
        return pts_y[a] < pts_y[b];
    endfunction

    function automatic hull_t make_result(int idx, logic kind);
        hull_t r;
        r.x_out    = pts_x[idx][FIELD_W-1:0];
        r.y_out    = pts_y[idx][FIELD_W-1:0];
        r.kind     = kind;
        r.last_out = 1'b0;
        return r;
    endfunction

    function automatic void add_expected(int idx, logic kind);
        hull_queue.insert(hull_queue.size(), make_result(idx, kind));
    endfunction

    task automatic predict_hull();
        int order [MAX_POINTS];
        int stack [MAX_POINTS+1];
        int popped [MAX_POINTS];
        int n;
        int depth;
        int npop;
        int j;
        int k;
        n = 0;
        start_pt = 0;
        for (int i = 1; i < num_pts; i++)
            if (pts_x[i] < pts_x[start_pt] ||
                (pts_x[i] == pts_x[start_pt] && pts_y[i] < pts_y[start_pt]))
                start_pt = i;
        for (int i = 0; i < num_pts; i++)
        begin
            if (i == start_pt || same_pt(i, start_pt))
                continue;
            j = n;
            while (j > 0 && goes_first(i, order[j-1]))
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
            n++;
        end
        depth = 1;
        npop = 0;
        stack[0] = start_pt;
        for (int i = 0; i < n; i++)
        begin
            k = order[i];
            if (same_pt(k, stack[depth-1]))
                continue;
            // pop on strict right turns only
            while (depth >= 2 && turn_sign(stack[depth-2], stack[depth-1], k) < 0)
            begin
                popped[npop++] = stack[depth-1];
                depth--;
            end
            stack[depth++] = k;
        end
        for (int i = 0; i < depth; i++)
            add_expected(stack[i], KIND_HULL);
        add_expected(start_pt, KIND_HULL);
        for (int i = 0; i < npop; i++)
            add_expected(popped[i], KIND_REMOVED);
        hull_queue[hull_queue.size()-1].last_out = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        hull_t exp_r;
        if (!rst_n)
        begin
            num_pts    = 0;
            emitting   = 1'b0;
            fail_count = 0;
            hull_queue.delete();
        end
        else
        begin
            if (hull_valid && !hull_stall)
            begin
                if (hull_queue.size() == 0)
                begin
                    $error("hull transaction with nothing expected: %h", hull);
                    fail_count++;
                end
                else
                begin
                    exp_r = hull_queue.pop_front();
                    if (hull.x_out !== exp_r.x_out)
                    begin
                        $error("x_out expected %0d actual %0d", exp_r.x_out, hull.x_out);
                        fail_count++;
                    end
                    if (hull.y_out !== exp_r.y_out)
                    begin
                        $error("y_out expected %0d actual %0d", exp_r.y_out, hull.y_out);
                        fail_count++;
                    end
                    if (hull.kind !== exp_r.kind)
                    begin
                        $error("kind expected %0d actual %0d", exp_r.kind, hull.kind);
                        fail_count++;
                    end
                    if (hull.last_out !== exp_r.last_out)
                    begin
                        $error("last_out expected %0d actual %0d",
                               exp_r.last_out, hull.last_out);
                        fail_count++;
                    end
                    if (exp_r.last_out)
                    begin
                        emitting = 1'b0;
                        num_pts  = 0;
                    end
                end
            end
            // transactions while emitting only pace the output
            if (pt_valid && !pt_stall && !emitting)
            begin
                if (num_pts < MAX_POINTS)
                begin
                    pts_x[num_pts] = sext_coord(pt.x_coord);
                    pts_y[num_pts] = sext_coord(pt.y_coord);
                    num_pts++;
                end
                if (pt.last_point)
                begin
                    predict_hull();
                    emitting = 1'b1;
                end
            end
        end
    end

endmodule

@@ bench/tb_convex_hull_scan_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_convex_hull_scan_unit
// Drives point sets into the hull unit (directed shapes, then random sets)
// with random idling on both sides in the first two random phases; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_convex_hull_scan_unit;
    import chs_pkg::*;

    logic  clk;
    logic  rst_n;
    logic  pt_valid;
    logic  pt_stall;
    pt_t   pt;
    logic  hull_valid;
    logic  hull_stall;
    hull_t hull;
    int    fail_count;
    int    pending;
    int    send_idle;
    int    recv_idle;
    int    sent;

    convex_hull_scan_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pt_valid   (pt_valid),
        .pt_stall   (pt_stall),
        .pt         (pt),
        .hull_valid (hull_valid),
        .hull_stall (hull_stall),
        .hull       (hull)
    );

    convex_hull_scan_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pt_valid   (pt_valid),
        .pt_stall   (pt_stall),
        .pt         (pt),
        .hull_valid (hull_valid),
        .hull_stall (hull_stall),
        .hull       (hull),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(negedge clk)
        hull_stall <= ($urandom_range(99) < recv_idle);

    // one point transaction; valid stays high into the next call, idling drops it
    task automatic send_point(logic [15:0] x, logic [15:0] y, logic lst);
        while ($urandom_range(99) < send_idle)
        begin
            pt_valid <= 1'b0;
            @(negedge clk);
        end
        pt_valid <= 1'b1;
        pt       <= '{x_coord: x, y_coord: y, last_point: lst};
        @(posedge clk);
        while (pt_stall)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    // pace one transaction per remaining result after the first; content is ignored
    task automatic drain_hull();
        int paces;
        paces = pending - 1;
        repeat (paces)
            send_point(16'($urandom), 16'($urandom), 1'($urandom));
        pt_valid <= 1'b0;
        while (pending > 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic send_set(int n, int spread, bit dupes);
        logic [15:0] x;
        logic [15:0] y;
        for (int i = 0; i < n; i++)
        begin
            if (dupes && i > 0 && $urandom_range(3) == 0)
                ;
            else if (spread == 0)
            begin
                x = 16'($urandom);
                y = 16'($urandom);
            end
            else
            begin
                x = 16'($signed($urandom_range(2*spread)) - spread);
                y = 16'($signed($urandom_range(2*spread)) - spread);
            end
            send_point(x, y, i == n - 1);
        end
        drain_hull();
    endtask

    task automatic random_phase(int s_idle, int r_idle, int budget);
        int start;
        send_idle = s_idle;
        recv_idle = r_idle;
        start = sent;
        while (sent - start < budget)
            case ($urandom_range(9))
                0: send_set($urandom_range(40, 33), 0, 0);
                1: send_set($urandom_range(12, 1), 3, 1);
                2: send_set($urandom_range(20, 3), 0, 0);
                default: send_set($urandom_range(12, 2), $urandom_range(1000, 4), 1);
            endcase
    endtask

    initial
    begin
        rst_n      = 1'b0;
        pt_valid   = 1'b0;
        pt         = '0;
        send_idle  = 0;
        recv_idle  = 0;
        sent       = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // single point
        send_point(16'h8000, 16'h7fff, 1'b1);
        drain_hull();
        // extreme square with a duplicate of the start and a collinear edge point
        send_point(16'h7fff, 16'h7fff, 1'b0);
        send_point(16'h8000, 16'h8000, 1'b0);
        send_point(16'h7fff, 16'h8000, 1'b0);
        send_point(16'h8000, 16'h8000, 1'b0);
        send_point(16'h0000, 16'h8000, 1'b0);
        send_point(16'h0000, 16'h0000, 1'b0);
        send_point(16'h8000, 16'h7fff, 1'b1);
        drain_hull();
        // vertical collinear tie above the start, all points on one line
        send_point(16'd5, 16'd3, 1'b0);
        send_point(16'd5, 16'd1, 1'b0);
        send_point(16'd5, 16'd9, 1'b0);
        send_point(16'd5, 16'd1, 1'b1);
        drain_hull();
        // store overflow: last point beyond the store
        send_set(36, 0, 0);
        random_phase(26, 54, 110);
        random_phase(54, 26, 110);
        random_phase(0, 0, 110);
        repeat (50) @(negedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/chs_pkg.sv
rtl/core/chs_orient.sv
rtl/core/chs_seq.sv
rtl/core/convex_hull_scan_unit.sv
rtl/core/chs_checker.sv
bench/convex_hull_scan_checker.sv
bench/tb_convex_hull_scan_unit.sv
